FILE: sv/dcm_pkg.sv
package dcm_pkg;

    typedef struct packed {
        logic signed [31:0] drive_voltage;
        logic signed [31:0] load_torque;
    } t_in;

    typedef struct packed {
        logic signed [31:0] armature_current;
        logic signed [31:0] angular_speed;
        logic signed [31:0] speed_rpm;
    } t_out;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_CONSTANT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RESISTANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DAMPING    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEC_RATIO     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MECH_RATIO     = 3'd4;

    localparam logic [30:0] RST_MOTOR_CONSTANT = 31'd18350;
    localparam logic [30:0] RST_INV_RESISTANCE = 31'd131072;
    localparam logic [30:0] RST_INV_DAMPING    = 31'd327680000;
    localparam logic [31:0] RST_ELEC_RATIO     = 32'd134217728;
    localparam logic [31:0] RST_MECH_RATIO     = 32'd85899;

    // 60 / (2 * 3.1415) in Q8.24
    localparam logic [31:0] RPM_FACTOR  = 32'd160215337;
    localparam int          RPM_SHIFT   = 24;
    localparam int          RATIO_SHIFT = 32;

    typedef enum logic [2:0] {
        U_NOP,
        U_ALU,
        U_MUL,
        U_DIV,
        U_TGT,
        U_OUT
    } t_kind;

    typedef enum logic [1:0] {
        A_STATE,
        A_TGT,
        A_VOLT,
        A_PROD
    } t_asel;

    typedef enum logic [2:0] {
        B_ZERO,
        B_HALF_P,
        B_PROD,
        B_LOAD,
        B_ACC,
        B_STATE,
        B_QUOT
    } t_bsel;

    typedef enum logic {
        D_ACC,
        D_STATE
    } t_dest;

    typedef enum logic [2:0] {
        M_MC,
        M_IR,
        M_ID,
        M_RATIO,
        M_RPM
    } t_msel;

    typedef enum logic [1:0] {
        S_NONE,
        S_LOAD,
        S_DBL,
        S_ONE
    } t_sum;

    typedef enum logic [1:0] {
        SH_FRAC,
        SH_RATIO,
        SH_RPM
    } t_shift;

    typedef struct packed {
        t_kind kind;
        t_asel a_sel;
        t_bsel b_sel;
        logic  sub;
        t_dest dest;
        logic  mech;
        t_msel msel;
        t_sum  sum;
    } t_uop;

    typedef struct packed {
        logic go;
        logic in_load;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } t_stat;

    localparam int PC_W = 6;

    localparam logic [PC_W-1:0] LAG_E_BASE = 6'd5;
    localparam logic [PC_W-1:0] LAG_M_BASE = 6'd24;
    localparam logic [PC_W-1:0] LAG_LEN    = 6'd14;

    function automatic t_uop uop_ctl(input t_kind kind, input t_sum sum);
        t_uop u;
        u.kind  = kind;
        u.a_sel = A_STATE;
        u.b_sel = B_ZERO;
        u.sub   = 1'b0;
        u.dest  = D_ACC;
        u.mech  = 1'b0;
        u.msel  = M_MC;
        u.sum   = sum;
        return u;
    endfunction

    function automatic t_uop uop_alu(input t_asel a_sel, input t_bsel b_sel, input logic sub,
                                     input t_dest dest, input logic mech, input t_sum sum);
        t_uop u;
        u       = uop_ctl(U_ALU, sum);
        u.a_sel = a_sel;
        u.b_sel = b_sel;
        u.sub   = sub;
        u.dest  = dest;
        u.mech  = mech;
        return u;
    endfunction

    function automatic t_uop uop_mul(input t_msel msel, input logic mech);
        t_uop u;
        u      = uop_ctl(U_MUL, S_NONE);
        u.msel = msel;
        u.mech = mech;
        return u;
    endfunction

    // one rk4 lag step, x is the state picked by mech
    function automatic t_uop lag_uop(input logic [3:0] idx, input logic mech);
        t_uop u;
        unique case (idx)
            4'd0:    u = uop_alu(A_TGT, B_STATE, 1'b1, D_ACC, mech, S_NONE);
            4'd1:    u = uop_mul(M_RATIO, mech);
            4'd2:    u = uop_alu(A_STATE, B_HALF_P, 1'b0, D_ACC, mech, S_LOAD);
            4'd3:    u = uop_alu(A_TGT, B_ACC, 1'b1, D_ACC, mech, S_NONE);
            4'd4:    u = uop_mul(M_RATIO, mech);
            4'd5:    u = uop_alu(A_STATE, B_HALF_P, 1'b0, D_ACC, mech, S_DBL);
            4'd6:    u = uop_alu(A_TGT, B_ACC, 1'b1, D_ACC, mech, S_NONE);
            4'd7:    u = uop_mul(M_RATIO, mech);
            4'd8:    u = uop_alu(A_STATE, B_PROD, 1'b0, D_ACC, mech, S_DBL);
            4'd9:    u = uop_alu(A_TGT, B_ACC, 1'b1, D_ACC, mech, S_NONE);
            4'd10:   u = uop_mul(M_RATIO, mech);
            4'd11:   u = uop_ctl(U_NOP, S_ONE);
            4'd12:   u = uop_ctl(U_DIV, S_NONE);
            4'd13:   u = uop_alu(A_STATE, B_QUOT, 1'b0, D_STATE, mech, S_NONE);
            default: u = uop_ctl(U_NOP, S_NONE);
        endcase
        return u;
    endfunction

    function automatic t_uop dcm_uop(input logic [PC_W-1:0] pc);
        t_uop u;
        if (pc >= LAG_E_BASE && pc < LAG_E_BASE + LAG_LEN) begin
            u = lag_uop(4'(pc - LAG_E_BASE), 1'b0);
        end else if (pc >= LAG_M_BASE && pc < LAG_M_BASE + LAG_LEN) begin
            u = lag_uop(4'(pc - LAG_M_BASE), 1'b1);
        end else begin
            unique case (pc)
                6'd0:    u = uop_alu(A_STATE, B_ZERO, 1'b0, D_ACC, 1'b1, S_NONE);
                6'd1:    u = uop_mul(M_MC, 1'b0);
                6'd2:    u = uop_alu(A_VOLT, B_PROD, 1'b1, D_ACC, 1'b0, S_NONE);
                6'd3:    u = uop_mul(M_IR, 1'b0);
                6'd4:    u = uop_ctl(U_TGT, S_NONE);
                6'd19:   u = uop_alu(A_STATE, B_ZERO, 1'b0, D_ACC, 1'b0, S_NONE);
                6'd20:   u = uop_mul(M_MC, 1'b0);
                6'd21:   u = uop_alu(A_PROD, B_LOAD, 1'b1, D_ACC, 1'b0, S_NONE);
                6'd22:   u = uop_mul(M_ID, 1'b1);
                6'd23:   u = uop_ctl(U_TGT, S_NONE);
                6'd38:   u = uop_alu(A_STATE, B_ZERO, 1'b0, D_ACC, 1'b1, S_NONE);
                6'd39:   u = uop_mul(M_RPM, 1'b1);
                6'd40:   u = uop_ctl(U_OUT, S_NONE);
                default: u = uop_ctl(U_NOP, S_NONE);
            endcase
        end
        return u;
    endfunction

endpackage

FILE: sv/dcm_mul.sv
module dcm_mul import dcm_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_a,
    input  logic        [31:0]           i_b,
    input  t_shift                       i_shift,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_res
);

    localparam int DW = DATA_WIDTH;
    localparam int NP = (DW + 31) / 32;
    localparam int MW = NP * 32;
    localparam int PW = MW + 32;
    localparam int CW = (NP > 1) ? $clog2(NP) : 1;

    localparam logic [DW-1:0] LIM_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] LIM_MIN = {1'b1, {(DW-1){1'b0}}};

    logic [MW-1:0] r_mag;
    logic          r_neg;
    logic [31:0]   r_b;
    t_shift        r_sh;
    logic [PW-1:0] r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_fin;
    logic          r_done;
    logic [DW-1:0] r_res;

    logic [DW-1:0] a_mag;
    logic [63:0]   part;
    logic          last;
    logic [PW-1:0] shifted;
    logic [DW-1:0] low;
    logic          over_pos;
    logic          over_neg;
    logic [DW-1:0] n_res;

    assign a_mag = i_a[DW-1] ? DW'(-i_a) : DW'(i_a);
    assign part  = 64'(r_mag[31:0]) * 64'(r_b);
    assign last  = (r_cnt == CW'(NP - 1));

    always_comb begin
        unique case (r_sh)
            SH_FRAC:  shifted = r_acc >> FRAC_BITS;
            SH_RATIO: shifted = r_acc >> RATIO_SHIFT;
            SH_RPM:   shifted = r_acc >> RPM_SHIFT;
            default:  shifted = r_acc >> FRAC_BITS;
        endcase
        low      = shifted[DW-1:0];
        over_pos = |shifted[PW-1:DW-1];
        over_neg = (|shifted[PW-1:DW]) || (shifted[DW-1] && (|shifted[DW-2:0]));
        if (r_neg) begin
            n_res = over_neg ? LIM_MIN : -low;
        end else begin
            n_res = over_pos ? LIM_MAX : low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // one 32-bit slice of the magnitude per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= MW'(a_mag);
            r_neg <= i_a[DW-1];
            r_b   <= i_b;
            r_sh  <= i_shift;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_mag <= MW'({32'd0, r_mag} >> 32);
            r_acc <= r_acc + (PW'(part) << {r_cnt, 5'd0});
            r_cnt <= r_cnt + CW'(1);
        end
        if (r_fin) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: sv/dcm_div6.sv
module dcm_div6 #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_num,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_quot
);

    localparam int DW = DATA_WIDTH;
    localparam int DG = (DW + 3) / 4;
    localparam int QW = DG * 4;
    localparam int CW = $clog2(DG);

    logic [QW-1:0] r_sh;
    logic [2:0]    r_rem;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_fin;
    logic          r_done;
    logic [DW-1:0] r_quot;

    logic [DW-1:0] n_mag;
    logic [6:0]    v;
    logic [12:0]   vp;
    logic [3:0]    qd;
    logic [6:0]    rem_full;
    logic          last;
    logic [DW-1:0] q;

    assign n_mag = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);

    // remainder stays below six, so v < 96 and v*43 >> 8 is the exact digit
    assign v        = {r_rem, r_sh[QW-1 -: 4]};
    assign vp       = 13'(v) * 13'd43;
    assign qd       = vp[11:8];
    assign rem_full = v - 7'(qd) * 7'd6;
    assign last     = (r_cnt == CW'(DG - 1));
    assign q        = r_sh[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // one hex digit per cycle, quotient shifts in behind the dividend
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= QW'(n_mag);
            r_rem <= 3'd0;
            r_neg <= i_num[DW-1];
            r_cnt <= '0;
        end else if (r_busy) begin
            r_sh  <= {r_sh[QW-5:0], qd};
            r_rem <= rem_full[2:0];
            r_cnt <= r_cnt + CW'(1);
        end
        if (r_fin) begin
            r_quot <= r_neg ? -q : q;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: sv/dcm_datapath.sv
module dcm_datapath import dcm_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in                   i_in_data,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output t_out                  o_out_data
);

    localparam int DW = DATA_WIDTH;
    localparam int AW = ((DW > 32) ? DW : 32) + 2;
    localparam int XW = (DW > 32) ? DW : 33;
    localparam bit FOLD_MIN = (DW == 64);

    localparam logic signed [DW-1:0] LIM_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] LIM_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [AW-1:0] MAX_EXT = AW'(LIM_MAX);
    localparam logic signed [AW-1:0] MIN_EXT = AW'(LIM_MIN);
    localparam logic signed [XW-1:0] O_MAX   = XW'(64'sd2147483647);
    localparam logic signed [XW-1:0] O_MIN   = XW'(-64'sd2147483648);

    logic [30:0]            r_mc;
    logic [30:0]            r_ir;
    logic [30:0]            r_id;
    logic [31:0]            r_er;
    logic [31:0]            r_mr;
    logic signed [DW-1:0]   r_cur;
    logic signed [DW-1:0]   r_spd;
    logic signed [31:0]     r_volt;
    logic signed [31:0]     r_load;
    logic signed [DW-1:0]   r_acc;
    logic signed [DW-1:0]   r_tgt;
    logic signed [DW-1:0]   r_sum;
    t_out                   r_out;

    t_uop                   uop;
    logic                   alu_we;
    logic                   mul_go;
    logic                   div_go;
    logic signed [DW-1:0]   state_sel;
    logic signed [DW-1:0]   prod;
    logic signed [DW-1:0]   quot;
    logic signed [DW-1:0]   p_adj;
    logic signed [DW-1:0]   half_p;
    logic signed [AW-1:0]   op_a;
    logic signed [AW-1:0]   op_b;
    logic signed [AW-1:0]   b_fix;
    logic signed [AW-1:0]   raw;
    logic signed [DW-1:0]   alu_res;
    logic signed [DW-1:0]   dbl_p;
    logic signed [DW-1:0]   n_sum;
    logic [31:0]            mul_b;
    t_shift                 mul_sh;
    logic                   mul_done;
    logic                   div_done;

    function automatic logic signed [AW-1:0] ext_dw(input logic signed [DW-1:0] v);
        return AW'(v);
    endfunction

    function automatic logic signed [AW-1:0] ext32(input logic signed [31:0] v);
        return AW'(v);
    endfunction

    function automatic logic signed [DW-1:0] clampd(input logic signed [AW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > MAX_EXT) begin
            r = LIM_MAX;
        end else if (v < MIN_EXT) begin
            r = LIM_MIN;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [DW-1:0] v);
        logic signed [XW-1:0] x;
        logic [31:0]          r;
        x = XW'(v);
        if (x > O_MAX) begin
            r = O_MAX[31:0];
        end else if (x < O_MIN) begin
            r = O_MIN[31:0];
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    assign uop       = i_cmd.uop;
    assign alu_we    = i_cmd.go && (uop.kind == U_ALU);
    assign mul_go    = i_cmd.go && (uop.kind == U_MUL);
    assign div_go    = i_cmd.go && (uop.kind == U_DIV);
    assign state_sel = uop.mech ? r_spd : r_cur;

    // halving rounds toward zero
    assign p_adj  = prod + $signed({{(DW-1){1'b0}}, prod[DW-1]});
    assign half_p = p_adj >>> 1;

    always_comb begin
        unique case (uop.a_sel)
            A_STATE: op_a = ext_dw(state_sel);
            A_TGT:   op_a = ext_dw(r_tgt);
            A_VOLT:  op_a = ext32(r_volt);
            A_PROD:  op_a = ext_dw(prod);
            default: op_a = ext_dw(state_sel);
        endcase
        unique case (uop.b_sel)
            B_ZERO:   op_b = '0;
            B_HALF_P: op_b = ext_dw(half_p);
            B_PROD:   op_b = ext_dw(prod);
            B_LOAD:   op_b = ext32(r_load);
            B_ACC:    op_b = ext_dw(r_acc);
            B_STATE:  op_b = ext_dw(state_sel);
            B_QUOT:   op_b = ext_dw(quot);
            default:  op_b = '0;
        endcase
        // at full 64-bit width the negated minimum folds to the maximum
        if (FOLD_MIN && uop.sub && (op_b == MIN_EXT)) begin
            b_fix = op_b + AW'(1);
        end else begin
            b_fix = op_b;
        end
        raw     = uop.sub ? (op_a - b_fix) : (op_a + b_fix);
        alu_res = clampd(raw);
    end

    always_comb begin
        dbl_p = clampd(ext_dw(prod) + ext_dw(prod));
        unique case (uop.sum)
            S_NONE:  n_sum = r_sum;
            S_LOAD:  n_sum = prod;
            S_DBL:   n_sum = clampd(ext_dw(r_sum) + ext_dw(dbl_p));
            S_ONE:   n_sum = clampd(ext_dw(r_sum) + ext_dw(prod));
            default: n_sum = r_sum;
        endcase
    end

    always_comb begin
        unique case (uop.msel)
            M_MC: begin
                mul_b  = {1'b0, r_mc};
                mul_sh = SH_FRAC;
            end
            M_IR: begin
                mul_b  = {1'b0, r_ir};
                mul_sh = SH_FRAC;
            end
            M_ID: begin
                mul_b  = {1'b0, r_id};
                mul_sh = SH_FRAC;
            end
            M_RATIO: begin
                mul_b  = uop.mech ? r_mr : r_er;
                mul_sh = SH_RATIO;
            end
            M_RPM: begin
                mul_b  = RPM_FACTOR;
                mul_sh = SH_RPM;
            end
            default: begin
                mul_b  = {1'b0, r_mc};
                mul_sh = SH_FRAC;
            end
        endcase
    end

    dcm_mul #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_go),
        .i_a     (r_acc),
        .i_b     (mul_b),
        .i_shift (mul_sh),
        .o_done  (mul_done),
        .o_res   (prod)
    );

    dcm_div6 #(
        .DATA_WIDTH (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (r_sum),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mc  <= RST_MOTOR_CONSTANT;
            r_ir  <= RST_INV_RESISTANCE;
            r_id  <= RST_INV_DAMPING;
            r_er  <= RST_ELEC_RATIO;
            r_mr  <= RST_MECH_RATIO;
            r_cur <= '0;
            r_spd <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MOTOR_CONSTANT: r_mc <= i_cfg_data[30:0];
                    CFG_INV_RESISTANCE: r_ir <= i_cfg_data[30:0];
                    CFG_INV_DAMPING:    r_id <= i_cfg_data[30:0];
                    CFG_ELEC_RATIO:     r_er <= i_cfg_data;
                    CFG_MECH_RATIO:     r_mr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (alu_we && (uop.dest == D_STATE)) begin
                if (uop.mech) begin
                    r_spd <= alu_res;
                end else begin
                    r_cur <= alu_res;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_volt <= i_in_data.drive_voltage;
            r_load <= i_in_data.load_torque;
        end
        if (alu_we && (uop.dest == D_ACC)) begin
            r_acc <= alu_res;
        end
        if (i_cmd.go) begin
            r_sum <= n_sum;
        end
        if (i_cmd.go && (uop.kind == U_TGT)) begin
            r_tgt <= prod;
        end
        if (i_cmd.go && (uop.kind == U_OUT)) begin
            r_out.armature_current <= sat32(r_cur);
            r_out.angular_speed    <= sat32(r_spd);
            r_out.speed_rpm        <= sat32(prod);
        end
    end

    assign o_stat.mul_done = mul_done;
    assign o_stat.div_done = div_done;
    assign o_out_data      = r_out;

endmodule

FILE: sv/dcm_ctrl.sv
module dcm_ctrl import dcm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            r_out_valid;
    logic            n_out_valid;
    t_uop            uop;
    logic            go;
    logic            in_load;

    assign uop = dcm_uop(r_pc);

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_out_valid = r_out_valid && i_out_stall;
        go          = 1'b0;
        in_load     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    in_load = 1'b1;
                    n_pc    = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                unique case (uop.kind)
                    U_MUL, U_DIV: begin
                        go      = 1'b1;
                        n_state = S_WAIT;
                    end
                    U_OUT: begin
                        // load the result beat only once the output slot is free
                        if (!r_out_valid || !i_out_stall) begin
                            go          = 1'b1;
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    default: begin
                        go   = 1'b1;
                        n_pc = r_pc + PC_W'(1);
                    end
                endcase
            end
            S_WAIT: begin
                if (i_stat.mul_done || i_stat.div_done) begin
                    n_pc    = r_pc + PC_W'(1);
                    n_state = S_RUN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.go      = go;
    assign o_cmd.in_load = in_load;
    assign o_cmd.uop     = uop;

endmodule

FILE: sv/dc_motor_rk4_step.sv
// dc motor model, one simulation tick per input beat
// input channel: drive voltage and load torque (signed Q16.16), accepted when
// i_in_valid is high and o_in_stall is low; output channel: armature current,
// rotor speed and speed in rpm, taken when o_out_valid is high and i_out_stall
// is low. configuration registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data; the user must write them only while no tick is in flight; the
// block itself does not enforce this. a sequencer walks a fixed micro-program
// over one shared multiplier and a digit-serial divide-by-six unit, one tick at
// a time. the micro-program runs thirteen products through the multiplier, each
// in NP = ceil(DATA_WIDTH/32) slices of 32 bits, and two divisions through the
// divider, each in DG = ceil(DATA_WIDTH/4) hex digits, one operation at a time.
// the next beat can be taken in the cycle after the result is loaded.
// the result sits in an output register; a stall there holds it and lets the
// next tick run, which waits at its end until the register is free.
// reset clears current and speed to zero and loads the default configuration.
module dc_motor_rk4_step import dcm_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    dcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    dcm_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_out_data)
    );

endmodule
